// ===== sv/coulomb_inverse_distance_assert.svh =====
// Assertion macros for the inverse-distance block.
// Used by the top level only; no other dependencies.
`ifndef COULOMB_INVERSE_DISTANCE_ASSERT_SVH
`define COULOMB_INVERSE_DISTANCE_ASSERT_SVH

// same-cycle implication
`define CID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cid_pkg.sv =====
// Types and constants for the inverse-distance block.
// No dependencies.
package cid_pkg;

  localparam int MaxDims   = 4;
  localparam int CoordW    = 32;
  localparam int DivCells  = 64;
  localparam int SqrtCells = 32;

  localparam logic [2:0]  DimsReset = 3'd3;
  localparam logic [31:0] PotMax    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] row_coord_0;
    logic signed [31:0] row_coord_1;
    logic signed [31:0] row_coord_2;
    logic signed [31:0] row_coord_3;
    logic signed [31:0] col_coord_0;
    logic signed [31:0] col_coord_1;
    logic signed [31:0] col_coord_2;
    logic signed [31:0] col_coord_3;
    logic               last_in_block;
  } cid_in_t;

  typedef struct packed {
    logic [31:0] potential;
    logic        zero_distance;
    logic        saturated;
    logic        last_out;
  } cid_out_t;

  // flags that ride alongside the pipeline
  typedef struct packed {
    logic        special;
    logic [31:0] pot_special;
    logic        zero;
    logic        sat;
    logic        last;
  } cid_side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] dvs;
    logic [63:0] quo;
    cid_side_t   side;
  } cid_div_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
    cid_side_t   side;
  } cid_sqrt_t;

endpackage

// ===== sv/cid_front.sv =====
// Front end: coordinate differences, squares, sum and case sorting.
// Depends on cid_pkg.
module cid_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  cid_pkg::cid_in_t  in_data,
  input  logic [2:0]        dims,
  output logic              out_vld,
  output cid_pkg::cid_div_t out_data
);

  logic signed [31:0] row_w [cid_pkg::MaxDims];
  logic signed [31:0] col_w [cid_pkg::MaxDims];
  logic [31:0]        mag_r [cid_pkg::MaxDims];
  logic [31:0]        mag_nxt [cid_pkg::MaxDims];
  logic [63:0]        sq_r [cid_pkg::MaxDims];
  logic [64:0]        ps0_r, ps1_r;
  logic [3:0]         vld_r;
  logic [2:0]         last_r;
  logic [65:0]        sum_w;
  logic [2:0]         use_w;
  cid_pkg::cid_div_t  out_r, out_nxt;

  // differences of the coordinates in use; dimensions above the maximum clamp
  always_comb begin
    row_w[0] = in_data.row_coord_0;
    row_w[1] = in_data.row_coord_1;
    row_w[2] = in_data.row_coord_2;
    row_w[3] = in_data.row_coord_3;
    col_w[0] = in_data.col_coord_0;
    col_w[1] = in_data.col_coord_1;
    col_w[2] = in_data.col_coord_2;
    col_w[3] = in_data.col_coord_3;
    use_w    = (dims > 3'(cid_pkg::MaxDims)) ? 3'(cid_pkg::MaxDims) : dims;
    for (int k = 0; k < cid_pkg::MaxDims; k++) begin
      if (k < int'(use_w)) begin
        mag_nxt[k] = (row_w[k] >= col_w[k]) ? 32'(row_w[k] - col_w[k])
                                            : 32'(col_w[k] - row_w[k]);
      end else begin
        mag_nxt[k] = '0;
      end
    end
  end

  // sum and case sorting; the divider computes floor(2^64 / sum)
  always_comb begin
    sum_w             = 66'(ps0_r) + 66'(ps1_r);
    out_nxt           = '0;
    out_nxt.rem       = 64'd1;
    out_nxt.dvs       = sum_w[63:0];
    out_nxt.side.last = last_r[2];
    if (sum_w == '0) begin
      out_nxt.side.special = 1'b1;
      out_nxt.side.zero    = 1'b1;
    end else if (sum_w[65:64] != 2'b00) begin
      out_nxt.side.special     = 1'b1;
      out_nxt.side.pot_special = (sum_w == 66'h1_0000_0000_0000_0000) ? 32'd1 : 32'd0;
    end else if (sum_w[63:0] == 64'd1) begin
      out_nxt.side.special     = 1'b1;
      out_nxt.side.pot_special = cid_pkg::PotMax;
      out_nxt.side.sat         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
    last_r <= {last_r[1:0], in_data.last_in_block};
    for (int k = 0; k < cid_pkg::MaxDims; k++) begin
      mag_r[k] <= mag_nxt[k];
      sq_r[k]  <= 64'(mag_r[k]) * 64'(mag_r[k]);
    end
    ps0_r <= 65'(sq_r[0]) + 65'(sq_r[1]);
    ps1_r <= 65'(sq_r[2]) + 65'(sq_r[3]);
    out_r <= out_nxt;
  end

  assign out_vld  = vld_r[3];
  assign out_data = out_r;

endmodule

// ===== sv/cid_div_cell.sv =====
// One restoring-division cell: one quotient bit per cycle.
// Depends on cid_pkg.
module cid_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  cid_pkg::cid_div_t in_data,
  output logic              out_vld,
  output cid_pkg::cid_div_t out_data
);

  logic              vld_r;
  cid_pkg::cid_div_t data_r, data_nxt;
  logic [64:0]       t_w;
  logic [64:0]       d_w;

  always_comb begin
    t_w      = {in_data.rem, 1'b0};
    d_w      = {1'b0, in_data.dvs};
    data_nxt = in_data;
    if (t_w >= d_w) begin
      data_nxt.rem = 64'(t_w - d_w);
      data_nxt.quo = {in_data.quo[62:0], 1'b1};
    end else begin
      data_nxt.rem = t_w[63:0];
      data_nxt.quo = {in_data.quo[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ===== sv/cid_sqrt_cell.sv =====
// One digit-by-digit square-root cell: one root bit per cycle.
// Depends on cid_pkg.
module cid_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  cid_pkg::cid_sqrt_t in_data,
  output logic               out_vld,
  output cid_pkg::cid_sqrt_t out_data
);

  logic               vld_r;
  cid_pkg::cid_sqrt_t data_r, data_nxt;
  logic [35:0]        t_w;
  logic [35:0]        trial_w;

  always_comb begin
    t_w          = {in_data.rem, in_data.rad[63:62]};
    trial_w      = {2'b00, in_data.root, 2'b01};
    data_nxt     = in_data;
    data_nxt.rad = {in_data.rad[61:0], 2'b00};
    if (t_w >= trial_w) begin
      data_nxt.rem  = 34'(t_w - trial_w);
      data_nxt.root = {in_data.root[30:0], 1'b1};
    end else begin
      data_nxt.rem  = t_w[33:0];
      data_nxt.root = {in_data.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ===== sv/coulomb_inverse_distance.sv =====
// Top level of the inverse-distance block: config register, front end,
//   division chain and square-root chain. Depends on cid_pkg, cid_front,
//   cid_div_cell, cid_sqrt_cell and coulomb_inverse_distance_assert.svh.
//
//   channel  ports                      transfer when
//   input    in_start, in_data          in_start && !in_busy
//   result   out_valid, out_data        out_valid (one cycle, no stall)
//   config   cfg_p*                     cfg_psel && cfg_penable && cfg_pwrite
//
// One pair per cycle; in_busy is never raised. Each pair passes through
// 4 front stages, 64 division cells, 32 root cells and one output register.
// Synchronous active-low reset clears valids and sets dimensions to 3.
// The receiver cannot stall; results appear for exactly one cycle.
`include "coulomb_inverse_distance_assert.svh"
module coulomb_inverse_distance (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_start,
  output logic              in_busy,
  input  cid_pkg::cid_in_t  in_data,
  output logic              out_valid,
  output cid_pkg::cid_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [2:0]         dims_r;
  logic               div_vld [cid_pkg::DivCells+1];
  cid_pkg::cid_div_t  div_dat [cid_pkg::DivCells+1];
  logic               sq_vld  [cid_pkg::SqrtCells+1];
  cid_pkg::cid_sqrt_t sq_dat  [cid_pkg::SqrtCells+1];
  logic               out_valid_r;
  cid_pkg::cid_out_t  out_data_r, out_data_nxt;
  cid_pkg::cid_side_t fin_side;

  assign in_busy    = 1'b0;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {29'd0, dims_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= cid_pkg::DimsReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      dims_r <= cfg_pwdata[2:0];
    end
  end

  cid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_start && !in_busy),
    .in_data  (in_data),
    .dims     (dims_r),
    .out_vld  (div_vld[0]),
    .out_data (div_dat[0])
  );

  for (genvar i = 0; i < cid_pkg::DivCells; i++) begin : g_div
    cid_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (div_vld[i]),
      .in_data  (div_dat[i]),
      .out_vld  (div_vld[i+1]),
      .out_data (div_dat[i+1])
    );
  end

  assign sq_vld[0]      = div_vld[cid_pkg::DivCells];
  assign sq_dat[0].rad  = div_dat[cid_pkg::DivCells].quo;
  assign sq_dat[0].rem  = '0;
  assign sq_dat[0].root = '0;
  assign sq_dat[0].side = div_dat[cid_pkg::DivCells].side;

  for (genvar j = 0; j < cid_pkg::SqrtCells; j++) begin : g_sqrt
    cid_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[j]),
      .in_data  (sq_dat[j]),
      .out_vld  (sq_vld[j+1]),
      .out_data (sq_dat[j+1])
    );
  end

  assign fin_side = sq_dat[cid_pkg::SqrtCells].side;

  always_comb begin
    out_data_nxt.potential     = fin_side.special ? fin_side.pot_special
                                                  : sq_dat[cid_pkg::SqrtCells].root;
    out_data_nxt.zero_distance = fin_side.zero;
    out_data_nxt.saturated     = fin_side.sat;
    out_data_nxt.last_out      = fin_side.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_vld[cid_pkg::SqrtCells];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CID_ASSERT_IMP(a_zero_out, clk, rst_n,
    out_valid && out_data.zero_distance,
    out_data.potential == '0 && !out_data.saturated, "zero distance with nonzero result")
  `CID_ASSERT_IMP(a_sat_max, clk, rst_n, out_valid && out_data.saturated,
    out_data.potential == cid_pkg::PotMax, "saturated result not at maximum")
  `CID_ASSERT_NXT(a_sqrt_last, clk, rst_n, sq_vld[cid_pkg::SqrtCells],
    out_valid, "root chain output not registered to result")

endmodule

// ===== test/tb.sv =====
// Testbench for coulomb_inverse_distance: random and directed point pairs,
//   results checked against a built-in inverse-distance predictor.
// Depends on cid_pkg and the coulomb_inverse_distance RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 101;
  localparam logic [2:0] AddrDims = 3'd0;

  class potential_board;
    logic [2:0]         dims;
    cid_pkg::cid_out_t  pending[$];
    int                 errors;

    function new();
      dims = cid_pkg::DimsReset;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function cid_pkg::cid_out_t potential_of(cid_pkg::cid_in_t d);
      cid_pkg::cid_out_t r;
      logic signed [31:0] a[4];
      logic signed [31:0] b[4];
      logic signed [32:0] diff;
      logic [65:0] sum;
      logic [63:0] q;
      logic [127:0] t;
      logic [32:0] root;
      int n;
      a = '{d.row_coord_0, d.row_coord_1, d.row_coord_2, d.row_coord_3};
      b = '{d.col_coord_0, d.col_coord_1, d.col_coord_2, d.col_coord_3};
      n = (dims > cid_pkg::MaxDims) ? cid_pkg::MaxDims : int'(dims);
      sum = '0;
      for (int k = 0; k < n; k++) begin
        diff = 33'(a[k]) - 33'(b[k]);
        if (diff < 0) diff = -diff;
        sum += 66'(unsigned'(diff)) * 66'(unsigned'(diff));
      end
      r = '0;
      r.last_out = d.last_in_block;
      if (sum == 0) begin
        r.zero_distance = 1'b1;
      end else if (sum[65:64] != 0) begin
        r.potential = (sum == 66'h1_0000_0000_0000_0000) ? 32'd1 : 32'd0;
      end else if (sum == 1) begin
        r.potential = cid_pkg::PotMax;
        r.saturated = 1'b1;
      end else begin
        q = 64'hFFFF_FFFF_FFFF_FFFF / sum[63:0];
        if (64'hFFFF_FFFF_FFFF_FFFF % sum[63:0] == sum[63:0] - 1) q++;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
          t = 128'(root | (33'd1 << i));
          if (t * t <= 128'(q)) root = root | (33'd1 << i);
        end
        if (root > 33'(cid_pkg::PotMax)) begin
          r.potential = cid_pkg::PotMax;
          r.saturated = 1'b1;
        end else begin
          r.potential = root[31:0];
        end
      end
      return r;
    endfunction

    function void note_pair(cid_pkg::cid_in_t d);
      pending.push_back(potential_of(d));
    endfunction

    task check_result(cid_pkg::cid_out_t got);
      cid_pkg::cid_out_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.potential !== want.potential)
        report($sformatf("potential %h, want %h", got.potential, want.potential));
      if (got.zero_distance !== want.zero_distance)
        report($sformatf("zero_distance %b, want %b", got.zero_distance,
                         want.zero_distance));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated %b, want %b", got.saturated, want.saturated));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %b, want %b", got.last_out, want.last_out));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_start;
  logic              in_busy;
  cid_pkg::cid_in_t  in_data;
  logic              out_valid;
  cid_pkg::cid_out_t out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [2:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  potential_board board = new();

  coulomb_inverse_distance u_top (
    .clk(clk), .rst_n(rst_n),
    .in_start(in_start), .in_busy(in_busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_start && !in_busy) board.note_pair(in_data);
    if (rst_n && out_valid) board.check_result(out_data);
  end

  task automatic write_dims(input logic [2:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AddrDims;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.dims = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic send_pair(input cid_pkg::cid_in_t d);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    if (gap > 0) begin
      in_start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_start <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_busy);
  endtask

  task automatic drain();
    in_start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic cid_pkg::cid_in_t make_pair(logic signed [31:0] r[4],
                                                 logic signed [31:0] c[4], logic last);
    cid_pkg::cid_in_t d;
    d.row_coord_0 = r[0]; d.row_coord_1 = r[1];
    d.row_coord_2 = r[2]; d.row_coord_3 = r[3];
    d.col_coord_0 = c[0]; d.col_coord_1 = c[1];
    d.col_coord_2 = c[2]; d.col_coord_3 = c[3];
    d.last_in_block = last;
    return d;
  endfunction

  function automatic cid_pkg::cid_in_t random_pair();
    logic signed [31:0] r[4];
    logic signed [31:0] c[4];
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      r[k] = $urandom();
      case (mode)
        0: c[k] = r[k];
        1: c[k] = r[k] + $signed(32'($urandom_range(0, 2))) - 1;
        2, 3, 4: c[k] = r[k] + $signed(32'($urandom_range(0, 32'h3_FFFF)))
                        - 32'sh2_0000;
        5, 6: c[k] = r[k] + $signed($urandom() >> $urandom_range(0, 31));
        default: c[k] = $urandom();
      endcase
    end
    return make_pair(r, c, 1'($urandom()));
  endfunction

  task automatic directed_pairs();
    logic signed [31:0] z[4];
    logic signed [31:0] o[4];
    logic signed [31:0] mx[4];
    logic signed [31:0] mn[4];
    logic signed [31:0] m1[4];
    z  = '{0, 0, 0, 0};
    o  = '{1, 0, 0, 0};
    mx = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    mn = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    m1 = '{-1, -1, -1, -1};
    send_pair(make_pair(z, z, 1'b0));
    send_pair(make_pair(mx, mx, 1'b1));
    send_pair(make_pair(o, z, 1'b0));
    send_pair(make_pair(z, o, 1'b1));
    send_pair(make_pair(z, mn, 1'b0));
    send_pair(make_pair(mx, mn, 1'b1));
    send_pair(make_pair(mn, mx, 1'b0));
    send_pair(make_pair(m1, z, 1'b1));
    send_pair(make_pair('{32'sh1_0000, 0, 0, 0}, z, 1'b0));
    send_pair(make_pair('{0, 2, 0, 0}, z, 1'b1));
    send_pair(make_pair('{0, 0, 0, 1}, z, 1'b0));
  endtask

  initial begin
    logic [2:0] phase_dims[8];
    int per_phase;
    phase_dims = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd4};
    rst_n = 1'b0;
    in_start = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_pairs();
    drain();
    per_phase = 206;
    foreach (phase_dims[p]) begin
      write_dims(phase_dims[p]);
      directed_pairs();
      for (int i = 0; i < per_phase; i++) send_pair(random_pair());
      drain();
    end
    repeat (Latency + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("coulomb_inverse_distance test passed");
    else
      $display("coulomb_inverse_distance test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("coulomb_inverse_distance test failed");
    $finish;
  end

endmodule
